// ===== rtl/tlt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlt_pkg
// types, constants and helpers shared by the track lifecycle table
// ----------------------------------------------------------------------------
package tlt_pkg;

  localparam int MaxTracks = 32;
  localparam int SlotW     = $clog2(MaxTracks);
  localparam int CountW    = 6;

  localparam logic [1:0] FUNC_NEW   = 2'd0;
  localparam logic [1:0] FUNC_HIT   = 2'd1;
  localparam logic [1:0] FUNC_MISS  = 2'd2;
  localparam logic [1:0] FUNC_SWEEP = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_DELETED = 3'd3;
  localparam logic [2:0] ST_SWEEP   = 3'd4;

  localparam logic [1:0] LIFE_INIT      = 2'd0;
  localparam logic [1:0] LIFE_TENTATIVE = 2'd1;
  localparam logic [1:0] LIFE_CONFIRMED = 2'd2;

  localparam logic [2:0] REG_VAR_LIMIT  = 3'd0;
  localparam logic [2:0] REG_CONFIRM    = 3'd1;
  localparam logic [2:0] REG_DROP       = 3'd2;
  localparam logic [2:0] REG_MAX_SCORE  = 3'd3;
  localparam logic [2:0] REG_INIT_SCORE = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  score;
    logic [1:0]  life;
    logic [15:0] var_x;
    logic [15:0] var_y;
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] length;
    logic [15:0] yaw;
  } slot_t;

  typedef struct packed {
    logic [15:0] var_limit;
    logic [2:0]  confirm;
    logic [2:0]  drop;
    logic [2:0]  max_score;
    logic [2:0]  init_score;
  } cfg_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic [2:0]  score;
    logic [1:0]  life;
    logic [15:0] height;
    logic [15:0] width;
    logic [15:0] length;
    logic [15:0] yaw;
    logic [5:0]  live;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_BLEND, S_EMIT, S_WAIT
  } state_t;

  // (9*old + new + 5) / 10, saturated; divide by reciprocal multiply
  function automatic logic [15:0] blend(input logic [15:0] old, input logic [15:0] meas);
    logic [19:0] num;
    logic [40:0] prod;
    logic [16:0] q;
    logic [19:0] r;
    num  = 20'(old) * 20'd9 + 20'(meas) + 20'd5;
    prod = 41'(num) * 41'd209715;
    q    = prod[37:21];
    r    = num - 20'(q) * 20'd10;
    if (r >= 20'd10) q = q + 17'd1;
    blend = q[16] ? 16'hFFFF : q[15:0];
  endfunction

endpackage

// ===== rtl/tlt_store.sv =====
// ----------------------------------------------------------------------------
// tlt_store
// slot memory with registered read and valid bits in flops
// ----------------------------------------------------------------------------
module tlt_store (
  input  logic                clk,
  input  logic                rst,
  input  logic [tlt_pkg::SlotW-1:0] rd_addr,
  output tlt_pkg::slot_t      rd_data,
  output logic                rd_valid,
  input  logic                wr_en,
  input  logic [tlt_pkg::SlotW-1:0] wr_addr,
  input  tlt_pkg::slot_t      wr_data,
  input  logic                set_en,
  input  logic                clr_en,
  input  logic [tlt_pkg::SlotW-1:0] vb_addr,
  output logic [tlt_pkg::MaxTracks-1:0] valid
);
  import tlt_pkg::*;

  slot_t mem [MaxTracks];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (set_en) begin
      valid[vb_addr] <= 1'b1;
    end else if (clr_en) begin
      valid[vb_addr] <= 1'b0;
    end
  end

endmodule

// ===== rtl/track_lifecycle_table.sv =====
// ----------------------------------------------------------------------------
// track_lifecycle_table
// table of up to 32 tracks: create, hit, miss and sweep deletion
// ----------------------------------------------------------------------------
// requests enter on s_axis (tuser: func; tdata: track_id, pos_var_x,
// pos_var_y, obj_height, obj_width, obj_length, yaw_angle). results leave on
// m_axis (tuser: status), one per hit, miss or new request; a sweep gives one
// result per deleted track and a closing sweep-done result, tlast marking
// the final one. configuration writes arrive on cfg_valid/cfg_ready with
// cfg_index and cfg_data and are taken at any time.
// a new request finds its free slot from the valid flops.
// hit and miss walk the slot memory one entry at a time to find the id; then
// a hit blends into the slot, a miss lowers its score, and the slot is written back.
// a sweep walks all 32 slots, then gives the closing result.
// the memory read port is the limit: one slot read per step.
// one request is in work at a time; s_axis_tready is low while a result
// waits, so a stalled receiver holds the block with the result steady.
// reset clears all valid bits together, so no clearing pass is needed;
// next_id, the live count and the registers return to their reset values.
// ----------------------------------------------------------------------------
module track_lifecycle_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // track_id, pos_var_x, pos_var_y, obj_height, obj_width, obj_length,
  // yaw_angle
  input  logic [127:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_id, score_sixths, life_state, smooth_height, smooth_width,
  // smooth_length, last_yaw, live_count, zero fill
  output logic [111:0] m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import tlt_pkg::*;

  cfg_t cfg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{var_limit: 16'd2304, confirm: 3'd5, drop: 3'd3,
               max_score: 3'd6, init_score: 3'd1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VAR_LIMIT:  cfg.var_limit  <= cfg_data;
        REG_CONFIRM:    cfg.confirm    <= cfg_data[2:0];
        REG_DROP:       cfg.drop       <= cfg_data[2:0];
        REG_MAX_SCORE:  cfg.max_score  <= cfg_data[2:0];
        REG_INIT_SCORE: cfg.init_score <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [2:0] ceil_s;
  assign ceil_s = (cfg.max_score > 3'd6) ? 3'd6 : cfg.max_score;

  state_t state, state_next;
  logic [127:0] req;
  logic [1:0]   func;
  logic [31:0]  tid;
  logic [SlotW-1:0] idx;
  logic [31:0]  next_id;
  logic [CountW-1:0] total;
  res_t res, res_next;
  logic         out_valid;
  logic         found;

  assign tid = req[31:0];

  logic [SlotW-1:0] rd_addr;
  slot_t rd_data, wr_data, cur;
  logic rd_valid, wr_en, set_en, clr_en;
  logic [SlotW-1:0] wr_addr;
  logic [MaxTracks-1:0] valid;

  tlt_store u_store (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .rd_data(rd_data),
    .rd_valid(rd_valid), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .set_en(set_en), .clr_en(clr_en), .vb_addr(wr_addr), .valid(valid)
  );

  assign rd_addr = idx;

  // lowest free slot
  logic [SlotW-1:0] free_s;
  logic             free_ok;
  always_comb begin
    free_s  = '0;
    free_ok = 1'b0;
    for (int i = MaxTracks - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_s  = SlotW'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic drop;
  assign drop = (rd_data.life == LIFE_CONFIRMED && rd_data.score <= cfg.drop) ||
                rd_data.var_x > cfg.var_limit || rd_data.var_y > cfg.var_limit ||
                rd_data.score == 3'd0;

  logic match;
  assign match = rd_valid && rd_data.id == tid;

  logic last_idx;
  assign last_idx = idx == SlotW'(MaxTracks - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_READ;
      S_READ:  state_next = (func == FUNC_NEW) ? S_EMIT : S_CHECK;
      S_CHECK: begin
        if (func == FUNC_SWEEP) begin
          if (rd_valid && drop) state_next = S_EMIT;
          else if (last_idx) state_next = S_EMIT;
          else state_next = S_READ;
        end else if (match) begin
          state_next = S_BLEND;
        end else if (last_idx) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_READ;
        end
      end
      S_BLEND: state_next = S_EMIT;
      S_EMIT:  state_next = S_WAIT;
      S_WAIT: begin
        if (m_axis_tready) begin
          if (res.last) state_next = S_IDLE;
          else if (last_idx) state_next = S_EMIT;
          else state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = state == S_IDLE;

  logic [3:0] sc_inc;
  assign sc_inc = 4'(cur.score) + 4'd1;

  always_comb begin
    wr_en   = 1'b0;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    wr_addr = idx;
    wr_data = cur;
    if (state == S_READ && func == FUNC_NEW && free_ok) begin
      wr_en   = 1'b1;
      set_en  = 1'b1;
      wr_addr = free_s;
      wr_data = '{id: next_id + 32'd1,
                  score: (cfg.init_score > ceil_s) ? ceil_s : cfg.init_score,
                  life: LIFE_INIT, var_x: req[47:32], var_y: req[63:48],
                  height: req[79:64], width: req[95:80], length: req[111:96],
                  yaw: req[127:112]};
    end else if (state == S_BLEND) begin
      wr_en = 1'b1;
      if (func == FUNC_HIT) begin
        wr_data.score  = (sc_inc > 4'(ceil_s)) ? ceil_s : sc_inc[2:0];
        wr_data.life   = (wr_data.score >= cfg.confirm) ? LIFE_CONFIRMED : LIFE_TENTATIVE;
        wr_data.var_x  = req[47:32];
        wr_data.var_y  = req[63:48];
        wr_data.height = blend(cur.height, req[79:64]);
        wr_data.width  = blend(cur.width, req[95:80]);
        wr_data.length = blend(cur.length, req[111:96]);
        wr_data.yaw    = req[127:112];
      end else if (cur.score != 3'd0) begin
        wr_data.score = cur.score - 3'd1;
      end
    end else if (state == S_CHECK && func == FUNC_SWEEP && rd_valid && drop) begin
      clr_en = 1'b1;
    end
  end

  // result formed from the working slot copy
  always_comb begin
    res_next      = '0;
    res_next.live = total;
    res_next.last = 1'b1;
    if (found) begin
      res_next.result_id = cur.id;
      res_next.score     = cur.score;
      res_next.life      = cur.life;
      res_next.height    = cur.height;
      res_next.width     = cur.width;
      res_next.length    = cur.length;
      res_next.yaw       = cur.yaw;
    end
    priority if (func == FUNC_SWEEP) begin
      res_next.status = found ? ST_DELETED : ST_SWEEP;
      res_next.last   = !found;
    end else if (func == FUNC_NEW) begin
      res_next.status = found ? ST_OK : ST_FULL;
    end else begin
      res_next.status = found ? ST_OK : ST_UNKNOWN;
      if (!found) res_next.result_id = tid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_id   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          idx   <= '0;
          found <= 1'b0;
          if (s_axis_tvalid) begin
            req  <= s_axis_tdata;
            func <= s_axis_tuser;
          end
        end
        S_READ: begin
          if (func == FUNC_NEW) begin
            if (free_ok) begin
              next_id <= next_id + 32'd1;
              total   <= total + CountW'(1);
              found   <= 1'b1;
              cur     <= wr_data;
            end
          end
        end
        S_CHECK: begin
          cur <= rd_data;
          if (func == FUNC_SWEEP) begin
            if (rd_valid && drop) begin
              total <= total - CountW'(1);
              found <= 1'b1;
            end else begin
              found <= 1'b0;
              if (!last_idx) idx <= idx + SlotW'(1);
            end
          end else if (match) begin
            found <= 1'b1;
          end else if (!last_idx) begin
            idx <= idx + SlotW'(1);
          end
        end
        S_BLEND: cur <= wr_data;
        S_EMIT: begin
          out_valid <= 1'b1;
          res       <= res_next;
        end
        S_WAIT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            found     <= 1'b0;
            if (!res.last && !last_idx) idx <= idx + SlotW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.last;
  assign m_axis_tuser  = res.status;
  assign m_axis_tdata  = {5'd0, res.live, res.yaw, res.length,
                          res.width, res.height, res.life, res.score, res.result_id};

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CountW'(MaxTracks))
    else $error("live count out of range");

endmodule
